### rtl/bds_pkg.sv
package bds_pkg;

	localparam int PIXEL_W = 8;
	localparam int CFG_W   = 11;
	localparam int PAIR_W  = PIXEL_W + 1;
	localparam int SUM_W   = PIXEL_W + 2;

	typedef logic [PIXEL_W-1:0] pixel_t;
	typedef logic [CFG_W-1:0]   cfg_data_t;
	typedef logic [1:0]         cfg_index_t;
	typedef logic [PAIR_W-1:0]  pair_t;
	typedef logic [SUM_W-1:0]   sum_t;

	localparam cfg_index_t CFG_IMAGE_WIDTH  = 2'd0;
	localparam cfg_index_t CFG_IMAGE_HEIGHT = 2'd1;

	localparam cfg_data_t CFG_DIM_RESET = 11'd1024;

	localparam sum_t ROUND_BIAS = 10'd2;

endpackage

### rtl/bds_ram.sv
module bds_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/box_downsample_2x2_unit.sv
// a block mean passes the stage 1 register and then the output register after its last pixel is accepted
// throughput: one pixel per clock while in_stall is low; the line buffer has one write and one read port
// and each pixel uses at most one of them
// reset: column and row counters, the left pixel and both valid flags clear, both sizes return to 1024
// the line buffer is not cleared; an entry is written before it is read unless the width grows within a row pair
module box_downsample_2x2_unit #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  bds_pkg::cfg_index_t   cfg_index,
	input  bds_pkg::cfg_data_t    cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  bds_pkg::pixel_t       pixel_in,
	output logic                  out_valid,
	input  logic                  out_stall,
	output bds_pkg::pixel_t       pixel_out,
	output logic                  frame_done
);

	import bds_pkg::*;

	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int WW = $clog2(MAX_COLS + 1);
	localparam int HW = $clog2(MAX_ROWS + 1);
	localparam int CMPW_C = (WW > CFG_W) ? WW : CFG_W;
	localparam int CMPW_R = (HW > CFG_W) ? HW : CFG_W;
	localparam int LINE_DEPTH = (MAX_COLS + 1) / 2;
	localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	cfg_data_t width_q;
	cfg_data_t height_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	pixel_t left_q;

	logic [WW-1:0] w_lim;
	logic [HW-1:0] h_lim;
	logic [WW-1:0] col_inc;
	logic [HW-1:0] row_inc;
	logic [CMPW_C-1:0] width_ext;
	logic [CMPW_R-1:0] height_ext;

	logic accept;
	logic pair_col;
	logic emit;
	logic last_blk;
	pair_t pair_sum;
	logic [AW-1:0] line_addr;

	logic ram_we;
	logic ram_re;
	pair_t ram_rdata;

	logic valid_s1;
	pair_t pair_s1;
	logic last_s1;
	logic out_ready;
	sum_t blk_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_DIM_RESET;
			height_q <= CFG_DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero acts as one, oversize acts as the maximum
	always_comb begin
		width_ext  = CMPW_C'(width_q);
		height_ext = CMPW_R'(height_q);
		if (width_q == '0) begin
			w_lim = WW'(1);
		end else if (width_ext > CMPW_C'(MAX_COLS)) begin
			w_lim = WW'(MAX_COLS);
		end else begin
			w_lim = WW'(width_ext);
		end
		if (height_q == '0) begin
			h_lim = HW'(1);
		end else if (height_ext > CMPW_R'(MAX_ROWS)) begin
			h_lim = HW'(MAX_ROWS);
		end else begin
			h_lim = HW'(height_ext);
		end
	end

	assign out_ready = !out_valid || !out_stall;
	assign in_stall  = valid_s1 && !out_ready;
	assign accept    = in_valid && !in_stall;

	assign col_inc   = WW'(col_q) + WW'(1);
	assign row_inc   = HW'(row_q) + HW'(1);
	assign pair_col  = col_q[0] && (WW'(col_q) < w_lim);
	assign emit      = pair_col && row_q[0] && (HW'(row_q) < h_lim);
	assign last_blk  = (col_inc >= {w_lim[WW-1:1], 1'b0}) &&
		(row_inc >= {h_lim[HW-1:1], 1'b0});
	assign pair_sum  = PAIR_W'(left_q) + PAIR_W'(pixel_in);
	assign line_addr = AW'(col_q >> 1);

	assign ram_we = accept && pair_col && !row_q[0];
	assign ram_re = accept && emit;

	bds_ram #(
		.WIDTH(PAIR_W),
		.DEPTH(LINE_DEPTH)
	) u_line (
		.clk  (clk),
		.we   (ram_we),
		.waddr(line_addr),
		.wdata(pair_sum),
		.re   (ram_re),
		.raddr(line_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (accept) begin
			if (!col_q[0]) begin
				left_q <= pixel_in;
			end
			if (col_inc >= w_lim) begin
				col_q <= '0;
				row_q <= (row_inc >= h_lim) ? '0 : RW'(row_inc);
			end else begin
				col_q <= CW'(col_inc);
			end
		end
	end

	// stage 1 waits for the line buffer read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= emit;
		end else if (out_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_re) begin
			pair_s1 <= pair_sum;
			last_s1 <= last_blk;
		end
	end

	assign blk_sum = SUM_W'(ram_rdata) + SUM_W'(pair_s1) + ROUND_BIAS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s1) begin
			pixel_out  <= blk_sum[SUM_W-1:2];
			frame_done <= last_s1;
		end
	end

`ifndef SYNTH
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled while the output path can drain");

	a_emit_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |=> valid_s1)
		else $error("line read issued but stage 1 not loaded");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && out_stall |=> valid_s1)
		else $error("stage 1 dropped while the output was stalled");

	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("line buffer read and write in the same cycle");
`endif

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import bds_pkg::*;

	localparam int MAX_COLS      = 1024;
	localparam int MAX_ROWS      = 1024;
	localparam int LINE_DEPTH    = MAX_COLS / 2;
	localparam int SIZE_FIELD_MAX = (1 << CFG_W) - 1;
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int RANDOM_ITEMS  = 600;
	localparam int SETTLE_CYCLES = 4;
	localparam int FULL_FRAME_MAX = 400;

	// indexes with no register behind them
	localparam cfg_index_t CFG_SPARE_A = 2'd2;
	localparam cfg_index_t CFG_SPARE_B = 2'd3;

	typedef enum logic {STEP_WRITE, STEP_PIXEL} step_kind_t;

	typedef struct packed {
		step_kind_t kind;
		cfg_index_t idx;
		cfg_data_t  data;
		pixel_t     px;
		logic       typed;
		pixel_t     want_mean;
		logic       want_done;
	} dir_step_t;

	typedef struct packed {
		pixel_t mean;
		logic   done;
	} block_mean_t;

	localparam int N_DIRECTED = 33;
	localparam dir_step_t DIRECTED [N_DIRECTED] = '{
		// 2x2 frames: full scale, all zero, rounding
		'{STEP_WRITE, CFG_IMAGE_WIDTH,  11'd2,    8'd0,   1'b0, 8'd0,   1'b0},
		'{STEP_WRITE, CFG_IMAGE_HEIGHT, 11'd2,    8'd0,   1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd255, 1'b1, 8'd255, 1'b1},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b1, 8'd0,   1'b1},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd1,   1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd1,   1'b0, 8'd0,   1'b0},
		// 3x3: odd last column and odd last row are dropped
		'{STEP_WRITE, CFG_IMAGE_WIDTH,  11'd3,    8'd0,   1'b0, 8'd0,   1'b0},
		'{STEP_WRITE, CFG_IMAGE_HEIGHT, 11'd3,    8'd0,   1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd10,  1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd20,  1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd99,  1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd30,  1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd40,  1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd99,  1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd99,  1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd99,  1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd99,  1'b0, 8'd0,   1'b0},
		// zero width acts as one column, nothing comes out
		'{STEP_WRITE, CFG_IMAGE_WIDTH,  11'd0,    8'd0,   1'b0, 8'd0,   1'b0},
		'{STEP_WRITE, CFG_IMAGE_HEIGHT, 11'd2,    8'd0,   1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd200, 1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd201, 1'b0, 8'd0,   1'b0},
		// writes to unused indexes must not touch the sizes
		'{STEP_WRITE, CFG_SPARE_A,      11'h7FF,  8'd0,   1'b0, 8'd0,   1'b0},
		'{STEP_WRITE, CFG_SPARE_B,      11'h7FF,  8'd0,   1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd77,  1'b0, 8'd0,   1'b0},
		'{STEP_PIXEL, CFG_IMAGE_WIDTH,  11'd0,    8'd78,  1'b0, 8'd0,   1'b0}
	};

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	cfg_index_t cfg_index = CFG_IMAGE_WIDTH;
	cfg_data_t  cfg_data  = '0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	pixel_t     pixel_in  = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	pixel_t     pixel_out;
	logic       frame_done;

	// predictor state
	cfg_data_t size_w  = CFG_DIM_RESET;
	cfg_data_t size_h  = CFG_DIM_RESET;
	int        col_cnt = 0;
	int        row_cnt = 0;
	pixel_t    left_px = '0;
	pair_t     pair_line [LINE_DEPTH];

	block_mean_t pending_means [$];
	int          fail_count  = 0;
	int          sent_pixels = 0;
	int          cycle_cnt   = 0;
	int          stall_left  = 0;
	bit          no_gaps     = 1'b0;

	box_downsample_2x2_unit #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out),
		.frame_done(frame_done)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int clip_size(cfg_data_t v, int lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	// mostly short pauses, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic pixel_t rand_pixel();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return pixel_t'($urandom_range(0, 255));
	endfunction

	// cap keeps the effective width from growing in the middle of a row pair
	function automatic cfg_data_t pick_size(int cap);
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 80)
			return cfg_data_t'($urandom_range(1, cap < 12 ? cap : 12));
		if (r < 93 || cap < MAX_COLS)
			return cfg_data_t'($urandom_range(1, cap < 64 ? cap : 64));
		return cfg_data_t'($urandom_range(MAX_COLS, SIZE_FIELD_MAX));
	endfunction

	task automatic predict_box_mean(input pixel_t px, output bit produced,
			output block_mean_t res);
		int w, h, c, r, p, pair, total;
		w = clip_size(size_w, MAX_COLS);
		h = clip_size(size_h, MAX_ROWS);
		c = col_cnt;
		r = row_cnt;
		p = c >> 1;
		produced = 1'b0;
		res = '0;
		if (c % 2 == 0) begin
			left_px = px;
		end else if (c < w) begin
			pair = int'(left_px) + int'(px);
			if (r % 2 == 0) begin
				pair_line[p] = pair_t'(pair);
			end else if (r < h) begin
				total = int'(pair_line[p]) + pair;
				res.mean = pixel_t'((total + int'(ROUND_BIAS)) >> 2);
				res.done = (c + 1 >= (w & ~1)) && (r + 1 >= (h & ~1));
				produced = 1'b1;
			end
		end
		if (c + 1 >= w) begin
			col_cnt = 0;
			row_cnt = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_cnt = c + 1;
		end
	endtask

	task automatic send_pixel(input pixel_t px, input bit typed, input pixel_t want_mean,
			input logic want_done);
		int gap;
		bit produced;
		block_mean_t res;
		gap = no_gaps ? 0 : gap_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= px;
		do @(posedge clk); while (in_stall);
		predict_box_mean(px, produced, res);
		if (typed)
			pending_means.push_back('{want_mean, want_done});
		else if (produced)
			pending_means.push_back(res);
		sent_pixels++;
	endtask

	task automatic write_size(input cfg_index_t idx, input cfg_data_t val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IMAGE_WIDTH)
			size_w = val;
		else if (idx == CFG_IMAGE_HEIGHT)
			size_h = val;
		@(posedge clk);
	endtask

	// hold the input and let every pending mean come out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_means.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic flag_error(input string msg);
		if (fail_count < 10)
			$display("%s", msg);
		fail_count++;
	endtask

	always @(posedge clk) begin : check_means
		block_mean_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_means.size() == 0) begin
				flag_error($sformatf("unexpected transaction: pixel %0d done %0b",
					pixel_out, frame_done));
			end else begin
				want = pending_means.pop_front();
				if (pixel_out !== want.mean || frame_done !== want.done)
					flag_error($sformatf("expected pixel %0d done %0b, got pixel %0d done %0b",
						want.mean, want.done, pixel_out, frame_done));
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			stall_left <= no_gaps ? 0 : gap_len();
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("box_downsample_2x2_unit: mismatch");
			$finish;
		end
	end

	initial begin
		int random_start, cap, frame_len;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			if (DIRECTED[i].kind == STEP_WRITE) begin
				drain_results();
				write_size(DIRECTED[i].idx, DIRECTED[i].data);
			end else begin
				send_pixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].want_mean,
					DIRECTED[i].want_done);
			end
		end

		random_start = sent_pixels;
		while (sent_pixels - random_start < RANDOM_ITEMS) begin
			drain_results();
			no_gaps = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) != 0) begin
				// widening is only safe at the start of an even row
				cap = (col_cnt == 0 && row_cnt % 2 == 0) ? MAX_COLS
					: clip_size(size_w, MAX_COLS);
				write_size(CFG_IMAGE_WIDTH, pick_size(cap));
			end
			if ($urandom_range(0, 2) != 0)
				write_size(CFG_IMAGE_HEIGHT, pick_size(MAX_ROWS));
			if ($urandom_range(0, 11) == 0)
				write_size($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
					cfg_data_t'($urandom));
			frame_len = clip_size(size_w, MAX_COLS) * clip_size(size_h, MAX_ROWS);
			if ($urandom_range(0, 9) < 7 && frame_len <= FULL_FRAME_MAX) begin
				// finish the frame in flight, then up to two whole frames
				do send_pixel(rand_pixel(), 1'b0, '0, 1'b0);
				while (col_cnt != 0 || row_cnt != 0);
				repeat ($urandom_range(0, 2) * frame_len)
					send_pixel(rand_pixel(), 1'b0, '0, 1'b0);
			end else begin
				repeat ($urandom_range(1, 40)) send_pixel(rand_pixel(), 1'b0, '0, 1'b0);
			end
		end

		drain_results();
		if (fail_count == 0)
			$display("box_downsample_2x2_unit: match");
		else
			$display("box_downsample_2x2_unit: mismatch");
		$finish;
	end

endmodule

### sim.f
rtl/bds_pkg.sv
rtl/bds_ram.sv
rtl/box_downsample_2x2_unit.sv
bench/testbench.sv
